// File: hdl/token_bucket_rate_limiter_assert.svh
// Assertion macros for the token bucket rate limiter.
`ifndef TOKEN_BUCKET_RATE_LIMITER_ASSERT_SVH
`define TOKEN_BUCKET_RATE_LIMITER_ASSERT_SVH

`ifndef SYNTHESIS

`define TBRL_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define TBRL_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TBRL_ASSERT(name, clk, rst, prop, msg)

`define TBRL_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

// File: hdl/tbrl_pkg.sv
package tbrl_pkg;

   localparam int FRACTION_BITS_DEFAULT = 16;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 40;
   localparam int REFILL_WIDTH    = 32;
   localparam int CAPACITY_WIDTH  = 40;
   localparam int WAIT_WIDTH      = 20;
   localparam int BYTES_WIDTH     = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REFILL_PER_TICK = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BURST_CAPACITY  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_WAIT_TICKS  = 2'd2;

   localparam logic [WAIT_WIDTH-1:0] MAX_WAIT_RESET = 20'd100;

   localparam logic [1:0] ACTION_TICK    = 2'd0;
   localparam logic [1:0] ACTION_REQUEST = 2'd1;
   localparam logic [1:0] ACTION_REFILL  = 2'd2;

   localparam logic [2:0] STATUS_FULL        = 3'd0;
   localparam logic [2:0] STATUS_PARTIAL     = 3'd1;
   localparam logic [2:0] STATUS_AFTER_WAIT  = 3'd2;
   localparam logic [2:0] STATUS_BUSY        = 3'd3;
   localparam logic [2:0] STATUS_PASSTHROUGH = 3'd4;

   typedef struct packed {
      logic [1:0]             action;
      logic [BYTES_WIDTH-1:0] request_bytes;
   } req_payload_type;

   typedef struct packed {
      logic [BYTES_WIDTH-1:0] granted_bytes;
      logic [2:0]             grant_status;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } result_type;

   typedef struct packed {
      logic                       write_enable;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [CSR_DATA_WIDTH-1:0]  write_data;
   } csr_write_type;

endpackage

// File: hdl/tbrl_in_reg.sv
module tbrl_in_reg
   import tbrl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  req_payload_type req_payload,
   input  logic            advance,
   output logic            req_stall,
   output logic            item_valid,
   output req_payload_type item
);

   logic            item_valid_ff;
   logic            item_valid_in;
   req_payload_type item_ff;
   logic            load;

   assign req_stall = item_valid_ff && !advance;
   assign load = req_valid && !req_stall;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (load) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_payload;
      end
   end

   assign item_valid = item_valid_ff;
   assign item = item_ff;

endmodule

// File: hdl/tbrl_engine.sv
`include "token_bucket_rate_limiter_assert.svh"

module tbrl_engine
   import tbrl_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
)
(
   input  logic            clock,
   input  logic            reset,
   input  csr_write_type   csr,
   input  logic            item_valid,
   input  req_payload_type item,
   input  logic            advance,
   output result_type      result
);

   localparam int TOKEN_WIDTH = CAPACITY_WIDTH + FRACTION_BITS;

   logic [REFILL_WIDTH-1:0]   refill_ff;
   logic [CAPACITY_WIDTH-1:0] capacity_ff;
   logic [WAIT_WIDTH-1:0]     max_wait_ff;

   logic [TOKEN_WIDTH-1:0] token_ff;
   logic [TOKEN_WIDTH-1:0] token_in;
   logic                   waiting_ff;
   logic                   waiting_in;
   logic [BYTES_WIDTH-1:0] waiting_bytes_ff;
   logic [BYTES_WIDTH-1:0] waiting_bytes_in;
   logic [WAIT_WIDTH-1:0]  wait_count_ff;
   logic [WAIT_WIDTH-1:0]  wait_count_in;

   logic [TOKEN_WIDTH-1:0]    cap_fixed;
   logic [TOKEN_WIDTH:0]      sum;
   logic [TOKEN_WIDTH-1:0]    capped;
   logic [CAPACITY_WIDTH-1:0] whole_tick;
   logic [CAPACITY_WIDTH-1:0] whole_now;
   logic [CAPACITY_WIDTH-1:0] bytes_wide;
   logic [CAPACITY_WIDTH-1:0] waiting_wide;
   logic                      short_tick;
   logic [WAIT_WIDTH-1:0]     wait_next;
   logic [WAIT_WIDTH-1:0]     wait_limit;
   logic [BYTES_WIDTH-1:0]    permitted;
   logic                      fire;

   assign cap_fixed    = {capacity_ff, {FRACTION_BITS{1'b0}}};
   assign sum          = {1'b0, token_ff} + (TOKEN_WIDTH+1)'(refill_ff);
   assign capped       = (sum > {1'b0, cap_fixed}) ? cap_fixed : sum[TOKEN_WIDTH-1:0];
   assign whole_tick   = capped[TOKEN_WIDTH-1:FRACTION_BITS];
   assign whole_now    = token_ff[TOKEN_WIDTH-1:FRACTION_BITS];
   assign bytes_wide   = CAPACITY_WIDTH'(item.request_bytes);
   assign waiting_wide = CAPACITY_WIDTH'(waiting_bytes_ff);
   assign short_tick   = whole_tick < waiting_wide;
   assign wait_next    = (wait_count_ff == {WAIT_WIDTH{1'b1}}) ? wait_count_ff
                                                               : wait_count_ff + 1'b1;
   assign wait_limit   = (max_wait_ff == '0) ? WAIT_WIDTH'(1) : max_wait_ff;
   assign permitted    = short_tick ? whole_tick[BYTES_WIDTH-1:0] : waiting_bytes_ff;
   assign fire         = item_valid && advance;

   always_comb begin
      token_in         = token_ff;
      waiting_in       = waiting_ff;
      waiting_bytes_in = waiting_bytes_ff;
      wait_count_in    = wait_count_ff;
      result           = '0;
      unique case (item.action)
         ACTION_TICK: begin
            token_in = capped;
            if (waiting_ff) begin
               wait_count_in = wait_next;
               if (!(short_tick && (wait_next < wait_limit))) begin
                  token_in = capped - TOKEN_WIDTH'({permitted, {FRACTION_BITS{1'b0}}});
                  waiting_in       = 1'b0;
                  waiting_bytes_in = '0;
                  wait_count_in    = '0;
                  result.valid     = item_valid;
                  result.payload.granted_bytes =
                     (permitted == '0) ? BYTES_WIDTH'(1) : permitted;
                  result.payload.grant_status = STATUS_AFTER_WAIT;
               end
            end
         end
         ACTION_REQUEST: begin
            result.valid = item_valid;
            if (waiting_ff) begin
               result.payload.grant_status = STATUS_BUSY;
            end else if ((refill_ff == '0) || (item.request_bytes == '0)) begin
               result.payload.granted_bytes = item.request_bytes;
               result.payload.grant_status  = STATUS_PASSTHROUGH;
            end else if (whole_now >= bytes_wide) begin
               token_in = token_ff
                  - TOKEN_WIDTH'({item.request_bytes, {FRACTION_BITS{1'b0}}});
               result.payload.granted_bytes = item.request_bytes;
               result.payload.grant_status  = STATUS_FULL;
            end else begin
               token_in = '0;
               if (whole_now != '0) begin
                  result.payload.granted_bytes = whole_now[BYTES_WIDTH-1:0];
                  result.payload.grant_status  = STATUS_PARTIAL;
               end else begin
                  result.valid     = 1'b0;
                  waiting_in       = 1'b1;
                  waiting_bytes_in = item.request_bytes;
                  wait_count_in    = '0;
               end
            end
         end
         ACTION_REFILL: begin
            token_in = cap_fixed;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         refill_ff        <= '0;
         capacity_ff      <= '0;
         max_wait_ff      <= MAX_WAIT_RESET;
         token_ff         <= '0;
         waiting_ff       <= 1'b0;
         waiting_bytes_ff <= '0;
         wait_count_ff    <= '0;
      end else if (csr.write_enable) begin
         priority case (csr.index)
            CSR_REFILL_PER_TICK: refill_ff <= csr.write_data[REFILL_WIDTH-1:0];
            CSR_BURST_CAPACITY: begin
               capacity_ff <= csr.write_data[CAPACITY_WIDTH-1:0];
               token_ff    <= {csr.write_data[CAPACITY_WIDTH-1:0], {FRACTION_BITS{1'b0}}};
            end
            CSR_MAX_WAIT_TICKS: max_wait_ff <= csr.write_data[WAIT_WIDTH-1:0];
            default: begin
            end
         endcase
      end else if (fire) begin
         token_ff         <= token_in;
         waiting_ff       <= waiting_in;
         waiting_bytes_ff <= waiting_bytes_in;
         wait_count_ff    <= wait_count_in;
      end
   end

   `TBRL_ASSERT(token_within_cap, clock, reset, token_ff <= cap_fixed, "token level above cap")
   `TBRL_ASSERT(pending_has_size, clock, reset, waiting_ff |-> (waiting_bytes_ff != '0), "pending request of zero bytes")
   `TBRL_ASSERT(count_only_pending, clock, reset, (wait_count_ff != '0) |-> waiting_ff, "wait count without pending request")
   `TBRL_ASSERT(wait_grant_clears, clock, reset, (fire && !csr.write_enable && result.valid && (result.payload.grant_status == STATUS_AFTER_WAIT)) |=> !waiting_ff, "pending request survives its grant")

endmodule

// File: hdl/tbrl_out_reg.sv
module tbrl_out_reg
   import tbrl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  result_type      result,
   input  logic            advance,
   input  logic            rsp_stall,
   output logic            space,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload
);

   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_payload_ff;
   logic            load;

   assign space = !rsp_valid_ff || !rsp_stall;
   assign load  = advance && result.valid;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_payload_ff <= result.payload;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// File: hdl/token_bucket_rate_limiter.sv
// Token bucket rate limiter.
// An accepted item waits in the input register; any result is registered at the output.
// Throughput: one item per cycle unless stalled; refill, cap and compare are combinational.
// Reset (synchronous): tokens, pending request and wait count clear, refill and
// capacity read zero, maximum wait reads 100 ticks.
module token_bucket_rate_limiter
   import tbrl_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_payload_type            req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_payload_type            rsp_payload,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   logic            item_valid;
   req_payload_type item;
   logic            space;
   logic            advance;
   result_type      result;
   csr_write_type   csr;

   assign advance = item_valid && space;

   assign csr.write_enable = csr_write_enable;
   assign csr.index        = csr_index;
   assign csr.write_data   = csr_write_data;

   tbrl_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .advance     (advance),
      .req_stall   (req_stall),
      .item_valid  (item_valid),
      .item        (item)
   );

   tbrl_engine #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .item_valid (item_valid),
      .item       (item),
      .advance    (advance),
      .result     (result)
   );

   tbrl_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .result      (result),
      .advance     (advance),
      .rsp_stall   (rsp_stall),
      .space       (space),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule
